// ===== sv/salru_pkg.sv =====
`timescale 1ns / 1ps

package salru_pkg;

  localparam int ADDR_W     = 64;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Access kinds carried in a request.
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_STORE  = 2'd1;
  localparam logic [1:0] CMD_MODIFY = 2'd2;
  localparam logic [1:0] CMD_FETCH  = 2'd3;

  // Lookup outcomes.
  localparam logic [1:0] OUTC_HIT   = 2'd0;
  localparam logic [1:0] OUTC_MISS  = 2'd1;
  localparam logic [1:0] OUTC_EVICT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] address;
  } in_t;

  typedef struct packed {
    logic [1:0]       outcome;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    logic [CNT_W-1:0] eviction_count;
    logic             last;
  } out_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ===== sv/salru_ram.sv =====
`timescale 1ns / 1ps

module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/set_assoc_lru_cache_model_top.sv =====
// A result is loaded into the result register in the update state, after the row read
// with lookup; the second result of a modify is loaded at the edge where the first is
// taken. A load or store may enter while the previous one writes back its row, if the
// result register is free; a modify holds off the next request until its second result
// is loaded, and a fetch leaves the block idle. The read-modify-write of a set's row sets this pace.
// Reset (synchronous, active low) clears control, counters, configuration and the per-set
// row flags; there is no clearing pass over the tag memory.
`timescale 1ns / 1ps

module set_assoc_lru_cache_model_top #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Request channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  salru_pkg::in_t                      in_data,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output salru_pkg::out_t                     out_data,
  // Configuration write channel.
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [salru_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [salru_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Each set lives in one memory row: MAX_WAYS lines of {tag, valid, rank} plus the
  // set's fill count. Rank 0 marks the most recently used line.
  localparam int SW    = (MAX_SET_BITS < 1) ? 1 : MAX_SET_BITS;
  localparam int DEPTH = 1 << SW;
  localparam int RW    = (MAX_WAYS < 2) ? 1 : $clog2(MAX_WAYS);
  localparam int WIW   = RW;
  localparam int FW    = $clog2(MAX_WAYS + 1);
  localparam int TW    = salru_pkg::ADDR_W;
  localparam int LW    = TW + 1 + RW;
  localparam int ROW_W = MAX_WAYS * LW + FW;
  localparam int CW    = salru_pkg::CNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPD,
    S_HIT2
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [2:0] set_bits_r;
  logic [5:0] block_bits_r;
  logic [3:0] ways_r;

  // Per-set flag: the row was written since reset. A row without it reads as all zero.
  logic [DEPTH-1:0] row_vld_r;

  logic [CW-1:0] hit_total_r, miss_total_r, eviction_total_r;

  logic            out_valid_r;
  salru_pkg::out_t out_data_r;

  // Request under work.
  logic [TW-1:0]    tag_r;
  logic [SW-1:0]    set_r;
  logic             mod_r;
  logic             fwd_r;
  logic [ROW_W-1:0] row_r;
  logic [WIW-1:0]   way_r;
  logic [1:0]       outc_r;

  logic [ROW_W-1:0] rd_data;

  // Derived configuration.
  logic [6:0]    sb;
  logic [6:0]    sh;
  logic [FW-1:0] nw;

  logic [TW-1:0] addr_shifted;
  logic [SW-1:0] set_mask;
  logic [SW-1:0] set_new;
  logic [TW-1:0] tag_new;

  logic in_fire;
  logic out_free;
  logic wr_en;
  logic res_load;

  // Lookup stage.
  logic [ROW_W-1:0] look_row;
  logic [TW-1:0]    l_tag  [MAX_WAYS];
  logic             l_vld  [MAX_WAYS];
  logic [RW-1:0]    l_rank [MAX_WAYS];
  logic [FW-1:0]    l_fill;
  logic             hit_any;
  logic [WIW-1:0]   hit_way;
  logic [WIW-1:0]   victim;
  logic [RW-1:0]    best;
  logic             full;
  logic [WIW-1:0]   look_way;
  logic [1:0]       look_outc;

  // Update stage.
  logic [ROW_W-1:0] upd_row;
  logic [RW:0]      old_rank;
  logic [RW-1:0]    u_rank;
  logic             u_vld;
  logic [FW-1:0]    u_fill;

  logic [CW-1:0] hit_nxt, miss_nxt, evict_nxt;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign out_free = !out_valid_r || out_ready;
  // A load or store may enter while the previous one writes back its row; a modify
  // still owes its second result and holds off the next request.
  assign in_ready = (state_r == S_IDLE) || ((state_r == S_UPD) && out_free && !mod_r);
  assign in_fire  = in_valid && in_ready;
  assign wr_en    = (state_r == S_UPD) && out_free;
  // A finished lookup loads the result register as soon as it is free.
  assign res_load = ((state_r == S_UPD) || (state_r == S_HIT2)) && out_free;

  // Set index and tag of an incoming request.
  always_comb begin
    sb = (int'(set_bits_r) > MAX_SET_BITS) ? 7'(MAX_SET_BITS) : 7'(set_bits_r);
    sh = sb + 7'(block_bits_r);
    nw = (ways_r == 4'd0) ? FW'(1) :
         ((int'(ways_r) > MAX_WAYS) ? FW'(MAX_WAYS) : FW'(ways_r));
    addr_shifted = in_data.address >> block_bits_r;
    for (int i = 0; i < SW; i++) begin
      set_mask[i] = (7'(i) < sb);
    end
    set_new = addr_shifted[SW-1:0] & set_mask;
    tag_new = (sh >= 7'd64) ? '0 : (in_data.address >> sh);
  end

  salru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (DEPTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (set_r),
    .wdata (upd_row),
    .re    (in_fire),
    .raddr (set_new),
    .rdata (rd_data)
  );

  // Lookup: compare every line in use against the tag, pick the way to touch.
  always_comb begin
    if (fwd_r) begin
      // The row was written back in the same cycle it was read.
      look_row = row_r;
    end else if (row_vld_r[set_r]) begin
      look_row = rd_data;
    end else begin
      look_row = '0;
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      l_rank[w] = look_row[w*LW +: RW];
      l_vld[w]  = look_row[w*LW + RW];
      l_tag[w]  = look_row[w*LW + RW + 1 +: TW];
    end
    l_fill = look_row[MAX_WAYS*LW +: FW];

    // Lowest matching way wins when several lines hold the same tag.
    hit_any = 1'b0;
    hit_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if ((w < int'(nw)) && l_vld[w] && (l_tag[w] == tag_r)) begin
        hit_any = 1'b1;
        hit_way = WIW'(w);
      end
    end

    // Victim: largest rank among ways in use, lowest index on a tie.
    victim = '0;
    best   = l_rank[0];
    for (int w = 1; w < MAX_WAYS; w++) begin
      if ((w < int'(nw)) && (l_rank[w] > best)) begin
        best   = l_rank[w];
        victim = WIW'(w);
      end
    end

    full = (l_fill >= nw);
    if (hit_any) begin
      look_way  = hit_way;
      look_outc = salru_pkg::OUTC_HIT;
    end else if (!full) begin
      look_way  = WIW'(l_fill);
      look_outc = salru_pkg::OUTC_MISS;
    end else begin
      look_way  = victim;
      look_outc = salru_pkg::OUTC_EVICT;
    end
  end

  // Update: make the chosen way most recent, age the lines that were newer than it.
  always_comb begin
    upd_row  = row_r;
    old_rank = row_r[int'(way_r)*LW + RW] ? {1'b0, row_r[int'(way_r)*LW +: RW]}
                                           : (RW+1)'(MAX_WAYS);
    for (int i = 0; i < MAX_WAYS; i++) begin
      u_rank = row_r[i*LW +: RW];
      u_vld  = row_r[i*LW + RW];
      if (WIW'(i) == way_r) begin
        upd_row[i*LW +: RW]  = '0;
        upd_row[i*LW + RW]   = 1'b1;
        if (outc_r != salru_pkg::OUTC_HIT) begin
          upd_row[i*LW + RW + 1 +: TW] = tag_r;
        end
      end else if (u_vld && ({1'b0, u_rank} < old_rank)) begin
        upd_row[i*LW +: RW] = u_rank + RW'(1);
      end
    end
    u_fill = row_r[MAX_WAYS*LW +: FW];
    if (outc_r == salru_pkg::OUTC_MISS) begin
      upd_row[MAX_WAYS*LW +: FW] = u_fill + FW'(1);
    end
  end

  // Counter values after the current lookup.
  always_comb begin
    hit_nxt   = hit_total_r;
    miss_nxt  = miss_total_r;
    evict_nxt = eviction_total_r;
    if (state_r == S_HIT2) begin
      hit_nxt = salru_pkg::sat_inc(hit_total_r);
    end else if (outc_r == salru_pkg::OUTC_HIT) begin
      hit_nxt = salru_pkg::sat_inc(hit_total_r);
    end else begin
      miss_nxt = salru_pkg::sat_inc(miss_total_r);
      if (outc_r == salru_pkg::OUTC_EVICT) begin
        evict_nxt = salru_pkg::sat_inc(eviction_total_r);
      end
    end
  end

  // Control, counters, configuration and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      out_valid_r      <= 1'b0;
      hit_total_r      <= '0;
      miss_total_r     <= '0;
      eviction_total_r <= '0;
      set_bits_r       <= 3'd0;
      block_bits_r     <= 6'd0;
      ways_r           <= 4'd1;
      row_vld_r        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          salru_pkg::CFG_SET_BITS:   set_bits_r   <= cfg_data[2:0];
          salru_pkg::CFG_BLOCK_BITS: block_bits_r <= cfg_data[5:0];
          salru_pkg::CFG_WAYS:       ways_r       <= cfg_data[3:0];
          default: ;
        endcase
      end

      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire && (in_data.command != salru_pkg::CMD_FETCH)) begin
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (out_free) begin
            hit_total_r              <= hit_nxt;
            miss_total_r             <= miss_nxt;
            eviction_total_r         <= evict_nxt;
            row_vld_r[set_r]         <= 1'b1;
            out_data_r.outcome        <= outc_r;
            out_data_r.hit_count      <= hit_nxt;
            out_data_r.miss_count     <= miss_nxt;
            out_data_r.eviction_count <= evict_nxt;
            out_data_r.last           <= !mod_r;
            if (mod_r) begin
              state_r <= S_HIT2;
            end else if (in_fire && (in_data.command != salru_pkg::CMD_FETCH)) begin
              state_r <= S_LOOK;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_HIT2: begin
          // The second lookup of a modify finds the line just touched: it is already
          // most recent, so only the hit counter moves.
          if (out_free) begin
            hit_total_r               <= hit_nxt;
            out_data_r.outcome        <= salru_pkg::OUTC_HIT;
            out_data_r.hit_count      <= hit_nxt;
            out_data_r.miss_count     <= miss_total_r;
            out_data_r.eviction_count <= eviction_total_r;
            out_data_r.last           <= 1'b1;
            state_r                   <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Request fields and the working copy of the set's row.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      tag_r <= tag_new;
      set_r <= set_new;
      mod_r <= (in_data.command == salru_pkg::CMD_MODIFY);
      // Same set as the row being written back this cycle: take the new row directly.
      fwd_r <= (state_r == S_UPD) && (set_new == set_r);
    end
    if (state_r == S_LOOK) begin
      row_r  <= look_row;
      way_r  <= look_way;
      outc_r <= look_outc;
    end else if (wr_en) begin
      row_r <= upd_row;
    end
  end

  // The lookup stage only ever follows an accepted request.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK) |-> $past(in_valid && in_ready))
    else $error("lookup stage entered without an accepted request");

  // An eviction is always also a miss.
  assert property (@(posedge clk) disable iff (!rst_n)
    eviction_total_r <= miss_total_r)
    else $error("eviction total exceeds miss total");

  // The hit and miss counters never move backward.
  assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (hit_total_r >= $past(hit_total_r)) && (miss_total_r >= $past(miss_total_r)))
    else $error("a running counter decreased");

  // The first result of a modify waits only while its second lookup is pending.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.last) |-> (state_r == S_HIT2))
    else $error("non-final result held outside the second lookup of a modify");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

  // Sizes of the tag store as the block is built by default.
  localparam int MAX_SB = 6;
  localparam int MAX_WY = 8;
  localparam int SETS   = 1 << MAX_SB;
  localparam int AW     = salru_pkg::ADDR_W;
  localparam int CW     = salru_pkg::CNT_W;
  localparam int IW     = salru_pkg::CFG_IDX_W;
  localparam int DW     = salru_pkg::CFG_DATA_W;

  // Index 3 has no register behind it; a write there must change nothing.
  localparam logic [IW-1:0] CFG_SPARE = 2'd3;

  // Quiet cycles after the last result cover a fetch still in flight behind it
  // before the configuration is touched.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SEGMENTS      = 15;
  localparam int SEGMENT_ITEMS = 120;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  salru_pkg::in_t  in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  salru_pkg::out_t out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [IW-1:0]   cfg_index = '0;
  logic [DW-1:0]   cfg_data  = '0;

  set_assoc_lru_cache_model_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Idle rates in percent of cycles, changed only while the block is quiet.
  int snd_idle_pct = 36;
  int rcv_idle_pct = 78;

  int fault_count = 0;
  int cycles      = 0;

  // Shadow copy of the cache tags, the recency ranks and the running totals.
  // Rank 0 marks the most recently used line of a set.
  logic [AW-1:0] tag_mem   [SETS][MAX_WY];
  bit            line_ok   [SETS][MAX_WY];
  logic [2:0]    line_rank [SETS][MAX_WY];
  logic [3:0]    set_fill  [SETS];
  logic [CW-1:0] hits, misses, evictions;
  logic [2:0]    sb_reg;
  logic [5:0]    bb_reg;
  logic [3:0]    ways_reg;

  // Results the block still owes us, oldest first.
  salru_pkg::out_t pending_results[$];

  // When the directed table pins an outcome, it overrides the computed one.
  bit         pin_on     = 1'b0;
  logic [1:0] pin_first  = salru_pkg::OUTC_HIT;
  logic [1:0] pin_second = salru_pkg::OUTC_HIT;

  // Effective geometry on the stimulus side, used to aim addresses at few sets.
  int cur_sb = 0;
  int cur_bb = 0;
  int cur_nw = 1;

  typedef struct {
    bit             is_cfg;
    logic [IW-1:0]  idx;
    logic [DW-1:0]  val;
    salru_pkg::in_t req;
    bit             pinned;
    logic [1:0]     first;
    logic [1:0]     second;
  } step_t;

  step_t plan[$];

  initial begin
    forever #5 clk = ~clk;
  end

  // The result side drops ready at random; a new draw every falling edge.
  initial begin
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // Watchdog. Covers a hung handshake as well as a result that never comes.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL set_assoc_lru_cache_model_top");
      $finish;
    end
  end

  function automatic logic [CW-1:0] bump(input logic [CW-1:0] v);
    return (v == salru_pkg::CNT_MAX) ? v : v + CW'(1);
  endfunction

  // Make line w of set s the most recently used; lines that were more recent
  // than it age by one rank.
  function automatic void promote_line(input int s, input int w);
    int old_rank;
    old_rank = line_ok[s][w] ? int'(line_rank[s][w]) : MAX_WY;
    for (int i = 0; i < MAX_WY; i++) begin
      if (i != w && line_ok[s][i] && int'(line_rank[s][i]) < old_rank)
        line_rank[s][i] = line_rank[s][i] + 3'd1;
    end
    line_rank[s][w] = '0;
    line_ok[s][w]   = 1'b1;
  endfunction

  // One tag lookup with fill or replacement; returns the outcome code.
  function automatic logic [1:0] cache_lookup(input logic [AW-1:0] addr);
    int sb, bb, nw, sh, s, fill, victim, best;
    logic [AW-1:0] tag;
    sb = (sb_reg > MAX_SB) ? MAX_SB : int'(sb_reg);
    bb = int'(bb_reg);
    nw = (ways_reg == 0) ? 1 : ((ways_reg > MAX_WY) ? MAX_WY : int'(ways_reg));
    sh = sb + bb;
    // A shift that swallows the whole address leaves an all-zero tag.
    tag  = (sh >= AW) ? '0 : addr >> sh;
    s    = int'((addr >> bb) & ((64'd1 << sb) - 64'd1));
    fill = int'(set_fill[s]);
    // After the way count changes, two lines may share a tag; the lowest wins.
    for (int w = 0; w < nw; w++) begin
      if (line_ok[s][w] && tag_mem[s][w] == tag) begin
        promote_line(s, w);
        hits = bump(hits);
        return salru_pkg::OUTC_HIT;
      end
    end
    misses = bump(misses);
    if (fill < nw) begin
      tag_mem[s][fill] = tag;
      promote_line(s, fill);
      set_fill[s] = 4'(fill + 1);
      return salru_pkg::OUTC_MISS;
    end
    // Full set, possibly over-full after the way count was lowered: the oldest
    // line in use goes, the lowest way on a tie.
    victim = 0;
    best   = 0;
    for (int w = 0; w < nw; w++) begin
      if (int'(line_rank[s][w]) > best || w == 0) begin
        best   = int'(line_rank[s][w]);
        victim = w;
      end
    end
    tag_mem[s][victim] = tag;
    promote_line(s, victim);
    evictions = bump(evictions);
    return salru_pkg::OUTC_EVICT;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fault_count++;
  endtask

  // Everything that happens at an edge is handled here in one fixed order:
  // first the result leaving, then a register write, then a new request.
  always @(posedge clk) begin : scoreboard
    salru_pkg::out_t want;
    logic [1:0]      outc;
    if (!rst_n) begin
      for (int s = 0; s < SETS; s++) begin
        set_fill[s] = '0;
        for (int w = 0; w < MAX_WY; w++) begin
          line_ok[s][w]   = 1'b0;
          line_rank[s][w] = '0;
        end
      end
      hits      = '0;
      misses    = '0;
      evictions = '0;
      sb_reg    = '0;
      bb_reg    = '0;
      ways_reg  = 4'd1;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("result with no request pending", 64'(out_data.outcome), '0);
        end else begin
          want = pending_results.pop_front();
          if (out_data.outcome !== want.outcome)
            flag_mismatch("outcome", 64'(out_data.outcome), 64'(want.outcome));
          if (out_data.hit_count !== want.hit_count)
            flag_mismatch("hit_count", 64'(out_data.hit_count), 64'(want.hit_count));
          if (out_data.miss_count !== want.miss_count)
            flag_mismatch("miss_count", 64'(out_data.miss_count), 64'(want.miss_count));
          if (out_data.eviction_count !== want.eviction_count)
            flag_mismatch("eviction_count", 64'(out_data.eviction_count),
                          64'(want.eviction_count));
          if (out_data.last !== want.last)
            flag_mismatch("last", 64'(out_data.last), 64'(want.last));
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          salru_pkg::CFG_SET_BITS:   sb_reg   = cfg_data[2:0];
          salru_pkg::CFG_BLOCK_BITS: bb_reg   = cfg_data[5:0];
          salru_pkg::CFG_WAYS:       ways_reg = cfg_data[3:0];
          default: ;
        endcase
      end

      // A fetch is dropped by the block and leaves no trace here either.
      if (in_valid && in_ready && in_data.command != salru_pkg::CMD_FETCH) begin
        outc = cache_lookup(in_data.address);
        want.outcome        = pin_on ? pin_first : outc;
        want.hit_count      = hits;
        want.miss_count     = misses;
        want.eviction_count = evictions;
        want.last           = (in_data.command != salru_pkg::CMD_MODIFY);
        pending_results.push_back(want);
        // The second half of a modify looks up the same address again.
        if (in_data.command == salru_pkg::CMD_MODIFY) begin
          outc = cache_lookup(in_data.address);
          want.outcome        = pin_on ? pin_second : outc;
          want.hit_count      = hits;
          want.miss_count     = misses;
          want.eviction_count = evictions;
          want.last           = 1'b1;
          pending_results.push_back(want);
        end
      end
    end
  end

  // Offers one request; entered and left at a falling edge. Idle cycles come
  // before the request is raised, never while it waits.
  task automatic send(input salru_pkg::in_t req);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drops the request line and waits out every owed result plus a margin for
  // a fetch that may still sit in the pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register. The valid is left high so that a following write
  // reuses it; the caller lowers it after the last write of a batch.
  task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  function automatic void add_cfg(input logic [IW-1:0] idx, input logic [DW-1:0] val);
    step_t st;
    st        = '{default: '0};
    st.is_cfg = 1'b1;
    st.idx    = idx;
    st.val    = val;
    plan.push_back(st);
  endfunction

  function automatic void add_req(input logic [1:0] cmd, input logic [AW-1:0] addr,
                                  input bit pinned = 1'b0,
                                  input logic [1:0] first = salru_pkg::OUTC_HIT,
                                  input logic [1:0] second = salru_pkg::OUTC_HIT);
    step_t st;
    st             = '{default: '0};
    st.req.command = cmd;
    st.req.address = addr;
    st.pinned      = pinned;
    st.first       = first;
    st.second      = second;
    plan.push_back(st);
  endfunction

  // Mostly accesses aimed at a handful of sets and small tags so that hits,
  // fills and replacements all happen often; the rest are wild addresses.
  function automatic logic [AW-1:0] pick_address();
    logic [AW-1:0] a;
    int            sh;
    a  = {$urandom, $urandom};
    sh = cur_sb + cur_bb;
    if ($urandom_range(0, 9) < 8) begin
      a = a & ((64'd1 << cur_bb) - 64'd1);
      a = a | (64'($urandom_range(0, 3) & ((1 << cur_sb) - 1)) << cur_bb);
      if (sh < AW)
        a = a | (64'($urandom_range(0, cur_nw + 2)) << sh);
    end
    return a;
  endfunction

  initial begin : stimulus
    bit             cfg_open;
    bit             moved;
    int             n;
    int             sbv, bbv, wv, pick;
    logic [1:0]     cmd;
    salru_pkg::in_t req;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table. With the reset geometry (one set, one way, no offset)
    // the first access misses and the second, with another tag, replaces it.
    add_req(salru_pkg::CMD_LOAD, 64'h100, 1'b1, salru_pkg::OUTC_MISS);
    add_req(salru_pkg::CMD_LOAD, 64'h200, 1'b1, salru_pkg::OUTC_EVICT);
    // Two sets of two ways with 16-byte blocks; set 0 still holds one line.
    add_cfg(salru_pkg::CFG_SET_BITS, 6'd1);
    add_cfg(salru_pkg::CFG_BLOCK_BITS, 6'd4);
    add_cfg(salru_pkg::CFG_WAYS, 6'd2);
    add_req(salru_pkg::CMD_LOAD, 64'h0, 1'b1, salru_pkg::OUTC_MISS);
    add_req(salru_pkg::CMD_LOAD, 64'hF, 1'b1, salru_pkg::OUTC_HIT);
    add_req(salru_pkg::CMD_STORE, 64'h10, 1'b1, salru_pkg::OUTC_MISS);
    add_req(salru_pkg::CMD_MODIFY, 64'h20, 1'b1, salru_pkg::OUTC_EVICT,
            salru_pkg::OUTC_HIT);
    add_req(salru_pkg::CMD_LOAD, 64'h40, 1'b1, salru_pkg::OUTC_EVICT);
    add_req(salru_pkg::CMD_LOAD, 64'h0, 1'b1, salru_pkg::OUTC_EVICT);
    add_req(salru_pkg::CMD_FETCH, '1);
    add_req(salru_pkg::CMD_LOAD, '1, 1'b1, salru_pkg::OUTC_MISS);
    add_req(salru_pkg::CMD_STORE, '1, 1'b1, salru_pkg::OUTC_HIT);
    // Set count above the maximum and a shift past the address width.
    add_cfg(salru_pkg::CFG_SET_BITS, 6'd7);
    add_cfg(salru_pkg::CFG_BLOCK_BITS, 6'd63);
    add_req(salru_pkg::CMD_LOAD, 64'h8000_0000_0000_0000);
    add_req(salru_pkg::CMD_MODIFY, 64'h0);
    // A way count of zero behaves as one, leaving sets over-full.
    add_cfg(salru_pkg::CFG_WAYS, 6'd0);
    add_req(salru_pkg::CMD_LOAD, 64'h1234);
    // One large set of eight ways (fifteen requested): fill it, then replace.
    add_cfg(salru_pkg::CFG_SET_BITS, 6'd0);
    add_cfg(salru_pkg::CFG_BLOCK_BITS, 6'd0);
    add_cfg(salru_pkg::CFG_WAYS, 6'd63);
    for (int i = 0; i < 9; i++) add_req(salru_pkg::CMD_LOAD, 64'h100 + 64'(i));
    // Shrinking to one way and missing copies a tag that lives further up;
    // after growing back, the lower of the two equal lines must be chosen.
    add_cfg(salru_pkg::CFG_WAYS, 6'd1);
    add_req(salru_pkg::CMD_LOAD, 64'h105);
    add_cfg(salru_pkg::CFG_WAYS, 6'd8);
    add_req(salru_pkg::CMD_MODIFY, 64'h105);
    add_cfg(CFG_SPARE, 6'd63);
    add_req(salru_pkg::CMD_STORE, 64'h0);

    cfg_open = 1'b0;
    moved    = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (moved) begin
          settle();
          moved = 1'b0;
        end
        write_reg(plan[i].idx, plan[i].val);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          @(negedge clk);
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
        end
        pin_on     = plan[i].pinned;
        pin_first  = plan[i].first;
        pin_second = plan[i].second;
        send(plan[i].req);
        pin_on = 1'b0;
        moved  = 1'b1;
      end
    end

    // Random segments, each under its own geometry. The first third has a slow
    // sender and a slower receiver, the second the reverse, the last runs flat out.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle();
      case (seg / 5)
        0: begin snd_idle_pct = 36; rcv_idle_pct = 78; end
        1: begin snd_idle_pct = 78; rcv_idle_pct = 36; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      case (seg)
        0:  begin sbv = 6; bbv = 0;  wv = 8;  end
        1:  begin sbv = 0; bbv = 63; wv = 1;  end
        5:  begin sbv = 7; bbv = 58; wv = 15; end
        10: begin sbv = 0; bbv = 0;  wv = 0;  end
        default: begin
          sbv  = $urandom_range(0, 7);
          pick = $urandom_range(0, 3);
          bbv  = (pick < 2) ? $urandom_range(0, 8) :
                 (pick == 2) ? $urandom_range(0, 63) : $urandom_range(50, 63);
          wv   = $urandom_range(0, 15);
        end
      endcase
      write_reg(salru_pkg::CFG_SET_BITS, 6'(sbv));
      write_reg(salru_pkg::CFG_BLOCK_BITS, 6'(bbv));
      write_reg(salru_pkg::CFG_WAYS, 6'(wv));
      @(negedge clk);
      cfg_valid <= 1'b0;
      cur_sb = (sbv > MAX_SB) ? MAX_SB : sbv;
      cur_bb = bbv;
      cur_nw = (wv == 0) ? 1 : ((wv > MAX_WY) ? MAX_WY : wv);

      // Fetches are mixed in but do not count toward the segment length.
      n = 0;
      while (n < SEGMENT_ITEMS) begin
        pick = $urandom_range(0, 15);
        cmd  = (pick < 5) ? salru_pkg::CMD_LOAD : (pick < 10) ? salru_pkg::CMD_STORE :
               (pick < 15) ? salru_pkg::CMD_MODIFY : salru_pkg::CMD_FETCH;
        req.command = cmd;
        req.address = pick_address();
        send(req);
        if (cmd != salru_pkg::CMD_FETCH) n++;
      end
    end

    settle();
    if (fault_count == 0) begin
      $display("PASS set_assoc_lru_cache_model_top");
    end else begin
      $display("FAIL set_assoc_lru_cache_model_top");
    end
    $finish;
  end

endmodule
